/* hdl/lmrs_pkg.sv */
// Package with the shared types and constants of the LED matrix row scanner.
`default_nettype none
package lmrs_pkg;

  localparam int unsigned ROW_COUNT_DEFAULT   = 25;
  localparam int unsigned COLUMN_BITS_DEFAULT = 32;

  localparam int unsigned DWELL_W     = 16;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned SEL_W       = 8;

  localparam logic [DWELL_W-1:0] DWELL_TICKS_RESET = 16'd750;
  localparam logic               SCAN_ENABLE_RESET = 1'b1;

  localparam logic [SEL_W-1:0] SEL_SPLIT_ROW = 8'd16;
  localparam logic [SEL_W-1:0] SEL_HIGH_BASE = 8'd15;
  localparam int unsigned      SEL_HIGH_SHIFT = 4;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_DWELL_TICKS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCAN_ENABLE = 1'd1;

  typedef enum logic [2:0] {
    PH_SHIFT_LIT,
    PH_SELECT,
    PH_LATCH_HI,
    PH_LATCH_LO,
    PH_DWELL,
    PH_SHIFT_BLANK,
    PH_BLANK_LATCH,
    PH_DESELECT
  } phase_e;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] column;
    logic [4:0] row_index;
    logic       pixel_value;
  } req_t;

  typedef struct packed {
    logic             serial_data;
    logic             shift_clock;
    logic             latch_strobe;
    logic [SEL_W-1:0] row_select;
  } rsp_t;

endpackage
`default_nettype wire

/* hdl/lmrs_frame.sv */
// Frame store of pixel rows with single pixel writes and a clear of the whole frame.
`default_nettype none
module lmrs_frame #(
  parameter int unsigned ROW_COUNT   = lmrs_pkg::ROW_COUNT_DEFAULT,
  parameter int unsigned COLUMN_BITS = lmrs_pkg::COLUMN_BITS_DEFAULT,
  localparam int unsigned RowW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   wr_en_i,
  input  wire logic                   clr_en_i,
  input  wire logic [4:0]             wr_row_i,
  input  wire logic [4:0]             wr_col_i,
  input  wire logic                   wr_val_i,
  input  wire logic [RowW-1:0]        rd_row_i,
  output logic      [COLUMN_BITS-1:0] rd_word_o
);
  import lmrs_pkg::*;

  logic [COLUMN_BITS-1:0] store_q [ROW_COUNT];
  logic [COLUMN_BITS-1:0] store_d [ROW_COUNT];

  always_comb begin
    for (int r = 0; r < ROW_COUNT; r++) begin
      store_d[r] = store_q[r];
      if (clr_en_i) begin
        store_d[r] = '0;
      end else if (wr_en_i && (wr_row_i == 5'(r))) begin
        for (int c = 0; c < COLUMN_BITS; c++) begin
          if (wr_col_i == 5'(c)) begin
            store_d[r][c] = wr_val_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROW_COUNT; r++) begin
        store_q[r] <= '0;
      end
    end else begin
      for (int r = 0; r < ROW_COUNT; r++) begin
        store_q[r] <= store_d[r];
      end
    end
  end

  assign rd_word_o = store_q[rd_row_i];

endmodule
`default_nettype wire

/* hdl/lmrs_scan.sv */
// Row scan sequencer that drives the shift, latch and row-select pin levels.
`default_nettype none
module lmrs_scan #(
  parameter int unsigned ROW_COUNT   = lmrs_pkg::ROW_COUNT_DEFAULT,
  parameter int unsigned COLUMN_BITS = lmrs_pkg::COLUMN_BITS_DEFAULT,
  localparam int unsigned RowW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          tick_i,
  input  wire logic [lmrs_pkg::DWELL_W-1:0]  dwell_ticks_i,
  input  wire logic [COLUMN_BITS-1:0]        row_word_i,
  output logic      [RowW-1:0]               row_o,
  output lmrs_pkg::rsp_t                     pins_o
);
  import lmrs_pkg::*;

  localparam int unsigned BitW = $clog2(COLUMN_BITS);
  localparam logic [BitW-1:0] LastBit = BitW'(COLUMN_BITS - 1);
  localparam logic [RowW-1:0] LastRow = RowW'(ROW_COUNT - 1);

  phase_e             phase_q, phase_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [BitW-1:0]    bit_q, bit_d;
  logic [DWELL_W-1:0] dwell_q, dwell_d;
  rsp_t               pins_q, pins_d;

  logic [BitW-1:0]    bit_idx;
  logic               shift_bit;
  logic [SEL_W-1:0]   row_num;
  logic [SEL_W-1:0]   row_code;
  logic [DWELL_W-1:0] dwell_inc;

  assign bit_idx   = LastBit - bit_q;
  assign shift_bit = (phase_q == PH_SHIFT_LIT) ? row_word_i[bit_idx] : 1'b0;
  assign row_num   = SEL_W'(row_q) + SEL_W'(1);
  assign row_code  = (row_num < SEL_SPLIT_ROW) ? row_num
                                               : ((row_num - SEL_HIGH_BASE) << SEL_HIGH_SHIFT);
  assign dwell_inc = dwell_q + DWELL_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SHIFT_LIT;
      row_q   <= '0;
      bit_q   <= '0;
      dwell_q <= '0;
      pins_q  <= '0;
    end else begin
      phase_q <= phase_d;
      row_q   <= row_d;
      bit_q   <= bit_d;
      dwell_q <= dwell_d;
      pins_q  <= pins_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    row_d   = row_q;
    bit_d   = bit_q;
    dwell_d = dwell_q;
    pins_d  = pins_q;
    if (tick_i) begin
      unique case (phase_q)
        PH_SHIFT_LIT, PH_SHIFT_BLANK: begin
          if (!pins_q.shift_clock) begin
            pins_d.serial_data = shift_bit;
            pins_d.shift_clock = 1'b1;
          end else begin
            pins_d.shift_clock = 1'b0;
            if (bit_q == LastBit) begin
              bit_d   = '0;
              phase_d = (phase_q == PH_SHIFT_LIT) ? PH_SELECT : PH_BLANK_LATCH;
            end else begin
              bit_d = bit_q + BitW'(1);
            end
          end
        end
        PH_SELECT: begin
          pins_d.row_select = row_code;
          phase_d           = PH_LATCH_HI;
        end
        PH_LATCH_HI: begin
          pins_d.latch_strobe = 1'b1;
          phase_d             = PH_LATCH_LO;
        end
        PH_LATCH_LO: begin
          pins_d.latch_strobe = 1'b0;
          dwell_d             = '0;
          phase_d             = (dwell_ticks_i == '0) ? PH_SHIFT_BLANK : PH_DWELL;
        end
        PH_DWELL: begin
          if (dwell_inc >= dwell_ticks_i) begin
            dwell_d = '0;
            phase_d = PH_SHIFT_BLANK;
          end else begin
            dwell_d = dwell_inc;
          end
        end
        PH_BLANK_LATCH: begin
          if (!pins_q.latch_strobe) begin
            pins_d.latch_strobe = 1'b1;
          end else begin
            pins_d.latch_strobe = 1'b0;
            phase_d             = PH_DESELECT;
          end
        end
        PH_DESELECT: begin
          pins_d.row_select = '0;
          row_d             = (row_q == LastRow) ? '0 : row_q + RowW'(1);
          phase_d           = PH_SHIFT_LIT;
        end
        default: begin
          phase_d = PH_SHIFT_LIT;
        end
      endcase
    end
  end

  assign row_o  = row_q;
  assign pins_o = pins_d;

endmodule
`default_nettype wire

/* hdl/lmrs_obuf.sv */
// Two-entry output buffer that keeps the input side moving while the receiver stalls.
`default_nettype none
module lmrs_obuf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire lmrs_pkg::rsp_t push_data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output lmrs_pkg::rsp_t      out_rsp_o
);
  import lmrs_pkg::*;

  rsp_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic pop;

  assign pop = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_q <= push_data_i;
      end else begin
        skid_q <= push_data_i;
      end
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
`default_nettype wire

/* hdl/led_matrix_row_scanner.sv */
// Top level of the LED matrix row scanner.
//
// Each input request is a tick, a pixel write or a frame clear. Every request
// produces exactly one response holding the pin levels after that request.
// Pixel writes and clears update the frame store and repeat the current pins;
// a tick advances the scan sequencer by one pin update while scanning is on.
// A request is processed in the cycle it is accepted and its response is
// registered in the output buffer. One request per clock is sustained while
// the output buffer is not full. A two-entry output buffer decouples the
// sides: input ready stays high while the receiver stalls until both entries
// hold responses. Configuration writes take effect at the next edge.
// Reset clears the frame store, the scan state and all pins, sets the dwell
// to 750 ticks and enables scanning.
`default_nettype none
module led_matrix_row_scanner #(
  parameter int unsigned ROW_COUNT   = lmrs_pkg::ROW_COUNT_DEFAULT,
  parameter int unsigned COLUMN_BITS = lmrs_pkg::COLUMN_BITS_DEFAULT
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [lmrs_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  wire logic [lmrs_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire lmrs_pkg::req_t                    in_req_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output lmrs_pkg::rsp_t                         out_rsp_o
);
  import lmrs_pkg::*;

  localparam int unsigned RowW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

  logic [DWELL_W-1:0]     dwell_ticks_q;
  logic                   scan_enable_q;
  logic                   accept;
  logic                   full;
  logic [RowW-1:0]        scan_row;
  logic [COLUMN_BITS-1:0] row_word;
  logic                   wr_ok;
  rsp_t                   pins;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_ticks_q <= DWELL_TICKS_RESET;
      scan_enable_q <= SCAN_ENABLE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DWELL_TICKS: dwell_ticks_q <= cfg_wdata_i[DWELL_W-1:0];
        CFG_SCAN_ENABLE: scan_enable_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;
  assign wr_ok      = ({1'b0, in_req_i.column} < 6'(COLUMN_BITS))
                   && ({1'b0, in_req_i.row_index} < 6'(ROW_COUNT));

  lmrs_frame #(
    .ROW_COUNT   (ROW_COUNT),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept && (in_req_i.action == ACT_WRITE) && wr_ok),
    .clr_en_i  (accept && (in_req_i.action == ACT_CLEAR)),
    .wr_row_i  (in_req_i.row_index),
    .wr_col_i  (in_req_i.column),
    .wr_val_i  (in_req_i.pixel_value),
    .rd_row_i  (scan_row),
    .rd_word_o (row_word)
  );

  lmrs_scan #(
    .ROW_COUNT   (ROW_COUNT),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (accept && (in_req_i.action == ACT_TICK) && scan_enable_q),
    .dwell_ticks_i (dwell_ticks_q),
    .row_word_i    (row_word),
    .row_o         (scan_row),
    .pins_o        (pins)
  );

  lmrs_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (pins),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
`default_nettype wire
